[design/cpa_pkg.sv]
// Shared constants, types and the CORDIC arctangent table for the closest-point-on-arc block.
// No dependencies; every other file of the block imports this package.
package cpa_pkg;

  localparam int COORD_BITS_DEF    = 24;
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // CORDIC gain compensation, 0.607252935 * 2^30 rounded up.
  localparam logic [29:0] GAIN_Q30 = 30'd652032875;

  // Register stages in each pipeline section.
  localparam int VEC_EXTRA = 3;
  localparam int ROT_EXTRA = 4;
  localparam int SEL_LAT   = 4;

  typedef enum logic [1:0] {
    SRC_RADIAL = 2'd0,
    SRC_START  = 2'd1,
    SRC_END    = 2'd2,
    SRC_CENTER = 2'd3
  } src_t;

  // Arctangent of 2^-i in 32-bit turn units (2^32 is one turn).
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] a;
    case (i)
      0:       a = 32'd536870912;
      1:       a = 32'd316933406;
      2:       a = 32'd167458907;
      3:       a = 32'd85004756;
      4:       a = 32'd42667331;
      5:       a = 32'd21354465;
      6:       a = 32'd10679838;
      7:       a = 32'd5340245;
      8:       a = 32'd2670163;
      9:       a = 32'd1335087;
      10:      a = 32'd667544;
      11:      a = 32'd333772;
      12:      a = 32'd166886;
      13:      a = 32'd83443;
      14:      a = 32'd41722;
      15:      a = 32'd20861;
      16:      a = 32'd10430;
      17:      a = 32'd5215;
      18:      a = 32'd2608;
      19:      a = 32'd1304;
      20:      a = 32'd652;
      21:      a = 32'd326;
      22:      a = 32'd163;
      23:      a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

[design/cpa_vec.sv]
// Pipelined vectoring CORDIC: radial angle of a query point around the arc centre.
// Depends on cpa_pkg for the arctangent table.
module cpa_vec import cpa_pkg::*; #(
  parameter int CB = COORD_BITS_DEF,
  parameter int AB = ANGLE_BITS_DEF,
  parameter int N  = CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [CB-1:0] qx,
  input  logic signed [CB-1:0] qy,
  input  logic signed [CB-1:0] cx,
  input  logic signed [CB-1:0] cy,
  output logic                 out_valid,
  output logic        [AB-1:0] angle
);

  localparam int SHIFT = 60 - CB;

  logic signed [CB:0] dx0, dy0;
  logic               zero0, v0;

  logic signed [63:0] vx [0:N];
  logic signed [63:0] vy [0:N];
  logic        [31:0] vz [0:N];
  logic               vv [0:N];
  logic               vzero [0:N];

  logic signed [63:0] dxs, dys;
  logic        [31:0] zsum;

  // Difference to the centre.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= in_valid;
    end
    dx0   <= (CB+1)'(qx) - (CB+1)'(cx);
    dy0   <= (CB+1)'(qy) - (CB+1)'(cy);
    zero0 <= (qx == cx) && (qy == cy);
  end

  assign dxs = 64'(dx0) <<< SHIFT;
  assign dys = 64'(dy0) <<< SHIFT;

  // Scale up and fold the left half plane onto the right.
  always_ff @(posedge clk) begin
    if (rst) begin
      vv[0] <= 1'b0;
    end else begin
      vv[0] <= v0;
    end
    vzero[0] <= zero0;
    if (dx0 < 0) begin
      vx[0] <= -dxs;
      vy[0] <= -dys;
      vz[0] <= 32'h8000_0000;
    end else begin
      vx[0] <= dxs;
      vy[0] <= dys;
      vz[0] <= 32'd0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (rst) begin
        vv[i+1] <= 1'b0;
      end else begin
        vv[i+1] <= vv[i];
      end
      vzero[i+1] <= vzero[i];
      if (vy[i] > 0) begin
        vx[i+1] <= vx[i] + (vy[i] >>> i);
        vy[i+1] <= vy[i] - (vx[i] >>> i);
        vz[i+1] <= vz[i] + atan_turn(i);
      end else begin
        vx[i+1] <= vx[i] - (vy[i] >>> i);
        vy[i+1] <= vy[i] + (vx[i] >>> i);
        vz[i+1] <= vz[i] - atan_turn(i);
      end
    end
  end

  assign zsum = vz[N] + (32'd1 << (31 - AB));

  // Round half up to the binary angle width.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vv[N];
    end
    angle <= vzero[N] ? '0 : zsum[31:32-AB];
  end

endmodule

[design/cpa_rot.sv]
// Pipelined rotating CORDIC: centre plus radius times (cos, sin) of a binary angle, saturated.
// Depends on cpa_pkg for the gain constant and the arctangent table.
module cpa_rot import cpa_pkg::*; #(
  parameter int CB = COORD_BITS_DEF,
  parameter int AB = ANGLE_BITS_DEF,
  parameter int N  = CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic        [AB-1:0] angle,
  input  logic        [CB-2:0] radius,
  input  logic signed [CB-1:0] cx,
  input  logic signed [CB-1:0] cy,
  output logic                 out_valid,
  output logic signed [CB-1:0] px,
  output logic signed [CB-1:0] py
);

  localparam int RW = CB + 33;
  localparam int SW = CB + 4;

  logic [31:0]    zt;
  logic           fold;
  logic [CB+28:0] prod;
  logic           negm, vm;
  logic [31:0]    zm;

  logic signed [RW-1:0] rx [0:N];
  logic signed [RW-1:0] ry [0:N];
  logic signed [31:0]   rz [0:N];
  logic                 rv [0:N];

  logic signed [RW-1:0] xr, yr;
  logic signed [CB+2:0] xq, yq;
  logic                 vq;
  logic signed [SW-1:0] sx, sy;
  logic signed [SW-1:0] hi, lo;

  assign zt   = {angle, (32-AB)'(0)};
  assign fold = (zt > 32'h4000_0000) && (zt < 32'hC000_0000);

  // Scaled radius; angles in the left half are turned by half a turn.
  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else begin
      vm <= in_valid;
    end
    prod <= (CB+29)'(radius) * (CB+29)'(GAIN_Q30);
    negm <= fold;
    zm   <= fold ? zt - 32'h8000_0000 : zt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv[0] <= 1'b0;
    end else begin
      rv[0] <= vm;
    end
    rx[0] <= negm ? -$signed(RW'(prod)) : $signed(RW'(prod));
    ry[0] <= '0;
    rz[0] <= $signed(zm);
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (rst) begin
        rv[i+1] <= 1'b0;
      end else begin
        rv[i+1] <= rv[i];
      end
      if (!rz[i][31]) begin
        rx[i+1] <= rx[i] - (ry[i] >>> i);
        ry[i+1] <= ry[i] + (rx[i] >>> i);
        rz[i+1] <= rz[i] - $signed(atan_turn(i));
      end else begin
        rx[i+1] <= rx[i] + (ry[i] >>> i);
        ry[i+1] <= ry[i] - (rx[i] >>> i);
        rz[i+1] <= rz[i] + $signed(atan_turn(i));
      end
    end
  end

  assign xr = rx[N] + (RW'(1) <<< 29);
  assign yr = ry[N] + (RW'(1) <<< 29);

  // Round half up to coordinate units.
  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= 1'b0;
    end else begin
      vq <= rv[N];
    end
    xq <= xr[RW-1:30];
    yq <= yr[RW-1:30];
  end

  assign sx = SW'(xq) + SW'(cx);
  assign sy = SW'(yq) + SW'(cy);
  assign hi = SW'((64'd1 << (CB - 1)) - 64'd1);
  assign lo = -hi - SW'(1);

  // Add the centre and clamp to the coordinate range.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vq;
    end
    px <= (sx > hi) ? hi[CB-1:0] : ((sx < lo) ? lo[CB-1:0] : sx[CB-1:0]);
    py <= (sy > hi) ? hi[CB-1:0] : ((sy < lo) ? lo[CB-1:0] : sy[CB-1:0]);
  end

endmodule

[design/cpa_sel.sv]
// Endpoint distance comparison and final result selection, four register stages.
// Depends on cpa_pkg for the result source codes.
module cpa_sel import cpa_pkg::*; #(
  parameter int CB = COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 zero_r,
  input  logic                 on_arc,
  input  logic signed [CB-1:0] qx,
  input  logic signed [CB-1:0] qy,
  input  logic signed [CB-1:0] rpx,
  input  logic signed [CB-1:0] rpy,
  input  logic signed [CB-1:0] spx,
  input  logic signed [CB-1:0] spy,
  input  logic signed [CB-1:0] epx,
  input  logic signed [CB-1:0] epy,
  input  logic signed [CB-1:0] cx,
  input  logic signed [CB-1:0] cy,
  output logic                 done,
  output logic signed [CB-1:0] closest_x,
  output logic signed [CB-1:0] closest_y,
  output src_t                 result_source
);

  typedef struct packed {
    logic                 zero_r;
    logic                 on_arc;
    logic signed [CB-1:0] rx;
    logic signed [CB-1:0] ry;
    logic signed [CB-1:0] sx;
    logic signed [CB-1:0] sy;
    logic signed [CB-1:0] ex;
    logic signed [CB-1:0] ey;
  } carry_t;

  carry_t c1, c2, c3;
  logic   v1, v2, v3;

  logic signed [CB:0] dsx, dsy, dex, dey;
  logic [CB-1:0]      asx, asy, aex, aey;
  logic [2*CB-1:0]    qsx, qsy, qex, qey;
  logic [2*CB:0]      ds, de;

  assign dsx = (CB+1)'(qx) - (CB+1)'(spx);
  assign dsy = (CB+1)'(qy) - (CB+1)'(spy);
  assign dex = (CB+1)'(qx) - (CB+1)'(epx);
  assign dey = (CB+1)'(qy) - (CB+1)'(epy);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= in_valid;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
    // Absolute differences.
    c1  <= '{zero_r: zero_r, on_arc: on_arc, rx: rpx, ry: rpy,
             sx: spx, sy: spy, ex: epx, ey: epy};
    asx <= dsx[CB] ? CB'(-dsx) : dsx[CB-1:0];
    asy <= dsy[CB] ? CB'(-dsy) : dsy[CB-1:0];
    aex <= dex[CB] ? CB'(-dex) : dex[CB-1:0];
    aey <= dey[CB] ? CB'(-dey) : dey[CB-1:0];
    // Squares.
    c2  <= c1;
    qsx <= (2*CB)'(asx) * (2*CB)'(asx);
    qsy <= (2*CB)'(asy) * (2*CB)'(asy);
    qex <= (2*CB)'(aex) * (2*CB)'(aex);
    qey <= (2*CB)'(aey) * (2*CB)'(aey);
    // Squared distances.
    c3  <= c2;
    ds  <= (2*CB+1)'(qsx) + (2*CB+1)'(qsy);
    de  <= (2*CB+1)'(qex) + (2*CB+1)'(qey);
    // Selection; a tie goes to the start endpoint.
    if (c3.zero_r) begin
      closest_x     <= cx;
      closest_y     <= cy;
      result_source <= SRC_CENTER;
    end else if (c3.on_arc) begin
      closest_x     <= c3.rx;
      closest_y     <= c3.ry;
      result_source <= SRC_RADIAL;
    end else if (ds <= de) begin
      closest_x     <= c3.sx;
      closest_y     <= c3.sy;
      result_source <= SRC_START;
    end else begin
      closest_x     <= c3.ex;
      closest_y     <= c3.ey;
      result_source <= SRC_END;
    end
  end

endmodule

[design/closest_point_on_arc.sv]
// Top level of the closest-point-on-arc block: configuration registers and pipeline glue.
// Depends on cpa_pkg, cpa_vec, cpa_rot and cpa_sel.
//
// The arc (centre, radius, start and end binary angles) is written through the
// configuration channel: a write lands at a rising edge with cfg_valid and
// cfg_ready high, cfg_index selecting the register in the order centre x,
// centre y, radius, start angle, end angle. Other indexes are ignored.
// cfg_ready is always high. Write configuration only while no request is in flight.
// A request (one query point) is taken at a rising edge with start high and
// busy low. The block is fully pipelined and takes a new request every cycle
// while busy is low. A vectoring CORDIC of CORDIC_STAGES+3 stages finds the
// radial angle, three rotating CORDICs of CORDIC_STAGES+4 stages each give the
// radial point and both endpoints side by side, and four stages compare the
// endpoint distances and pick the answer. The result is on the output ports
// for one cycle, marked by done; the receiver cannot stall, so nothing ever
// waits. Synchronous reset clears every in-flight request and the arc registers;
// busy is high during reset and for the cycle after it, and low otherwise.
module closest_point_on_arc import cpa_pkg::*; #(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  localparam int CFG_W = (COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  output logic                         done,
  output logic signed [COORD_BITS-1:0] closest_x,
  output logic signed [COORD_BITS-1:0] closest_y,
  output logic [1:0]                   result_source
);

  localparam int VEC_LAT = CORDIC_STAGES + VEC_EXTRA;
  localparam int ROT_LAT = CORDIC_STAGES + ROT_EXTRA;
  localparam int Q_LAT   = VEC_LAT + ROT_LAT;
  localparam int TOTAL   = Q_LAT + SEL_LAT;

  typedef enum logic [2:0] {
    CFG_CENTER_X    = 3'd0,
    CFG_CENTER_Y    = 3'd1,
    CFG_ARC_RADIUS  = 3'd2,
    CFG_START_ANGLE = 3'd3,
    CFG_END_ANGLE   = 3'd4
  } cfg_idx_t;

  logic signed [COORD_BITS-1:0] center_x, center_y;
  logic        [COORD_BITS-2:0] arc_radius;
  logic        [ANGLE_BITS-1:0] start_angle, end_angle;

  logic                  accept;
  logic                  ang_valid;
  logic [ANGLE_BITS-1:0] ang;
  logic [ANGLE_BITS-1:0] span, offset;
  logic                  rad_valid;

  logic signed [COORD_BITS-1:0] rpx, rpy, spx, spy, epx, epy;

  // Query coordinates and the on-arc flag ride alongside the CORDICs.
  logic signed [COORD_BITS-1:0] qx_line [0:Q_LAT-1];
  logic signed [COORD_BITS-1:0] qy_line [0:Q_LAT-1];
  logic                         arc_line [0:ROT_LAT-1];

  src_t src;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b1;
      center_x    <= '0;
      center_y    <= '0;
      arc_radius  <= '0;
      start_angle <= '0;
      end_angle   <= '0;
    end else begin
      busy <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CENTER_X:    center_x    <= cfg_data[COORD_BITS-1:0];
          CFG_CENTER_Y:    center_y    <= cfg_data[COORD_BITS-1:0];
          CFG_ARC_RADIUS:  arc_radius  <= cfg_data[COORD_BITS-2:0];
          CFG_START_ANGLE: start_angle <= cfg_data[ANGLE_BITS-1:0];
          CFG_END_ANGLE:   end_angle   <= cfg_data[ANGLE_BITS-1:0];
          default:         ;
        endcase
      end
    end
  end

  cpa_vec #(
    .CB(COORD_BITS), .AB(ANGLE_BITS), .N(CORDIC_STAGES)
  ) u_vec (
    .clk(clk), .rst(rst), .in_valid(accept),
    .qx(point_x), .qy(point_y), .cx(center_x), .cy(center_y),
    .out_valid(ang_valid), .angle(ang)
  );

  // The angle is on the arc when its offset from the start is within the span,
  // both taken modulo a full turn.
  assign span   = end_angle - start_angle;
  assign offset = ang - start_angle;

  always_ff @(posedge clk) begin
    qx_line[0]  <= point_x;
    qy_line[0]  <= point_y;
    arc_line[0] <= (offset <= span);
  end

  for (genvar k = 1; k < Q_LAT; k++) begin : g_qline
    always_ff @(posedge clk) begin
      qx_line[k] <= qx_line[k-1];
      qy_line[k] <= qy_line[k-1];
    end
  end

  for (genvar k = 1; k < ROT_LAT; k++) begin : g_aline
    always_ff @(posedge clk) begin
      arc_line[k] <= arc_line[k-1];
    end
  end

  // Radial point and both endpoints are computed side by side.
  cpa_rot #(
    .CB(COORD_BITS), .AB(ANGLE_BITS), .N(CORDIC_STAGES)
  ) u_rot_rad (
    .clk(clk), .rst(rst), .in_valid(ang_valid), .angle(ang),
    .radius(arc_radius), .cx(center_x), .cy(center_y),
    .out_valid(rad_valid), .px(rpx), .py(rpy)
  );

  cpa_rot #(
    .CB(COORD_BITS), .AB(ANGLE_BITS), .N(CORDIC_STAGES)
  ) u_rot_start (
    .clk(clk), .rst(rst), .in_valid(ang_valid), .angle(start_angle),
    .radius(arc_radius), .cx(center_x), .cy(center_y),
    .out_valid(), .px(spx), .py(spy)
  );

  cpa_rot #(
    .CB(COORD_BITS), .AB(ANGLE_BITS), .N(CORDIC_STAGES)
  ) u_rot_end (
    .clk(clk), .rst(rst), .in_valid(ang_valid), .angle(end_angle),
    .radius(arc_radius), .cx(center_x), .cy(center_y),
    .out_valid(), .px(epx), .py(epy)
  );

  cpa_sel #(
    .CB(COORD_BITS)
  ) u_sel (
    .clk(clk), .rst(rst), .in_valid(rad_valid),
    .zero_r(arc_radius == '0), .on_arc(arc_line[ROT_LAT-1]),
    .qx(qx_line[Q_LAT-1]), .qy(qy_line[Q_LAT-1]),
    .rpx(rpx), .rpy(rpy), .spx(spx), .spy(spy), .epx(epx), .epy(epy),
    .cx(center_x), .cy(center_y),
    .done(done), .closest_x(closest_x), .closest_y(closest_y),
    .result_source(src)
  );

  assign result_source = src;

  // Every request yields exactly one result.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##TOTAL done)
    else $error("request produced no result at the pipeline latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !accept |-> ##TOTAL !done)
    else $error("result without a matching request");

  a_quiet_after_reset: assert property (@(posedge clk)
    busy |-> !done)
    else $error("result strobe straight after reset");

endmodule
